>>> hdl/assert_macros.svh
// Assertion helpers used by indexed_list_store_core.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset.
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked on every clock edge, also during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> hdl/ils_pkg.sv
package ils_pkg;

  localparam int Depth  = 16;
  localparam int IdxW   = $clog2(Depth);
  localparam int CountW = 5;
  localparam int PosW   = 5;
  localparam int ValW   = 32;
  localparam int ReqW   = 3;
  localparam int StW    = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_GET    = 3'd3,
    REQ_SET    = 3'd4,
    REQ_INSERT = 3'd5,
    REQ_REMOVE = 3'd6
  } req_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ENT_KEEP   = 2'd0,
    ENT_WRITE  = 2'd1,
    ENT_INSERT = 2'd2,
    ENT_REMOVE = 2'd3
  } entry_op_e;

  typedef struct packed {
    entry_op_e              op;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] value;
  } entry_ctrl_t;

endpackage

>>> hdl/ils_entry_array.sv
module ils_entry_array
  import ils_pkg::*;
(
  input  logic                   clk_i,
  input  entry_ctrl_t            ctrl_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  output logic signed [ValW-1:0] rd_data_o
);

  logic signed [ValW-1:0] ent_q [Depth];
  logic signed [ValW-1:0] ent_d [Depth];
  logic signed [ValW-1:0] below [Depth];
  logic signed [ValW-1:0] above [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_ent
    localparam logic [IdxW-1:0] Idx = IdxW'(i);

    if (i == 0) begin : g_lo
      assign below[i] = ent_q[i];
    end else begin : g_lo_nb
      assign below[i] = ent_q[i-1];
    end
    if (i == Depth - 1) begin : g_hi
      assign above[i] = ent_q[i];
    end else begin : g_hi_nb
      assign above[i] = ent_q[i+1];
    end

    // Each entry keeps, takes a neighbor, or takes the new value.
    always_comb begin
      ent_d[i] = ent_q[i];
      case (ctrl_i.op)
        ENT_KEEP: ent_d[i] = ent_q[i];
        ENT_WRITE: begin
          if (Idx == ctrl_i.idx) ent_d[i] = ctrl_i.value;
        end
        ENT_INSERT: begin
          if (Idx == ctrl_i.idx) begin
            ent_d[i] = ctrl_i.value;
          end else if (Idx > ctrl_i.idx) begin
            ent_d[i] = below[i];
          end
        end
        ENT_REMOVE: begin
          if (Idx >= ctrl_i.idx) ent_d[i] = above[i];
        end
        default: ent_d[i] = ent_q[i];
      endcase
    end

    always_ff @(posedge clk_i) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign rd_data_o = ent_q[rd_idx_i];

endmodule

>>> hdl/indexed_list_store_core.sv
// A result is registered and appears on the master side in the cycle after its request is accepted.
// Throughput: one request per cycle; every entry updates in parallel in that cycle.
// The slave side stalls only while a held result is not taken.
// Reset (rst_ni low, asynchronous): the list is empty and no result is pending.
// Entry contents are not reset; only entries below the count are ever read.
`include "assert_macros.svh"

module indexed_list_store_core
  import ils_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] req_type, [7:3] position, [39:8] item_value
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_value, [33:32] status, [38:34] entry_count, [39] zero
  output logic [39:0] m_axis_tdata_o
);

  localparam logic [CountW-1:0] CountFull = CountW'(Depth);

  logic                   in_acc;
  logic [ReqW-1:0]        req;
  logic [PosW-1:0]        pos;
  logic signed [ValW-1:0] val;

  logic [CountW-1:0]      count_q, count_d;
  logic [CountW-1:0]      count_inc, count_dec;
  logic                   out_valid_q;
  logic signed [ValW-1:0] out_value_q, out_value_d;
  status_e                out_status_q, out_status_d;
  logic [CountW-1:0]      out_count_q;

  entry_ctrl_t            ctrl;
  logic [IdxW-1:0]        rd_idx;
  logic signed [ValW-1:0] rd_data;
  logic                   rd_en;
  logic                   empty, full, pos_lt, pos_le;

  assign req = s_axis_tdata_i[2:0];
  assign pos = s_axis_tdata_i[7:3];
  assign val = s_axis_tdata_i[39:8];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign count_inc = count_q + CountW'(1);
  assign count_dec = count_q - CountW'(1);

  assign empty  = (count_q == '0);
  assign full   = (count_q == CountFull);
  assign pos_lt = (pos < count_q);
  assign pos_le = (pos <= count_q);

  // Pop and peek read the top entry, get reads at the position.
  assign rd_idx = (req == REQ_POP || req == REQ_PEEK) ?
                  IdxW'(count_dec) : IdxW'(pos);

  always_comb begin
    ctrl.op      = ENT_KEEP;
    ctrl.idx     = IdxW'(pos);
    ctrl.value   = val;
    count_d      = count_q;
    out_status_d = ST_OK;
    rd_en        = 1'b0;
    case (req)
      REQ_PUSH: begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          ctrl.op  = ENT_WRITE;
          ctrl.idx = IdxW'(count_q);
          count_d  = count_inc;
        end
      end
      REQ_POP: begin
        if (empty) begin
          out_status_d = ST_BAD;
        end else begin
          rd_en   = 1'b1;
          count_d = count_dec;
        end
      end
      REQ_PEEK: begin
        if (empty) out_status_d = ST_BAD;
        else       rd_en = 1'b1;
      end
      REQ_GET: begin
        if (!pos_lt) out_status_d = ST_BAD;
        else         rd_en = 1'b1;
      end
      REQ_SET: begin
        if (!pos_lt) out_status_d = ST_BAD;
        else         ctrl.op = ENT_WRITE;
      end
      REQ_INSERT: begin
        if (!pos_le) begin
          out_status_d = ST_BAD;
        end else if (full) begin
          out_status_d = ST_FULL;
        end else begin
          ctrl.op = ENT_INSERT;
          count_d = count_inc;
        end
      end
      REQ_REMOVE: begin
        if (!pos_lt) begin
          out_status_d = ST_BAD;
        end else begin
          ctrl.op = ENT_REMOVE;
          count_d = count_dec;
        end
      end
      default: out_status_d = ST_BAD;
    endcase
    if (!in_acc) begin
      ctrl.op = ENT_KEEP;
      count_d = count_q;
    end
  end

  assign out_value_d = rd_en ? rd_data : '0;

  ils_entry_array u_entries (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_status_q, out_value_q};

  `ASSERT_RST(a_count_range, count_q <= CountFull)
  `ASSERT_RST(a_result_count, in_acc |=> out_count_q == count_q)
  `ASSERT_RST(a_full_status, out_valid_q && out_status_q == ST_FULL |-> out_count_q == CountFull)
  `ASSERT_RST(a_err_zero, out_valid_q && out_status_q != ST_OK |-> out_value_q == '0)
  `ASSERT_RST(a_count_idle, !in_acc |=> $stable(count_q))
  `ASSERT_RST(a_count_step, count_d == count_q || count_d == count_inc || count_d == count_dec)

endmodule

>>> tb/sv/indexed_list_store_core_tb.sv
module indexed_list_store_core_tb;
  import ils_pkg::*;

  localparam int                IdleLimit  = 500;
  localparam logic [ReqW-1:0]   ReqUnused  = 3'd7;
  localparam int                ModeGrow   = 0;
  localparam int                ModeMix    = 1;
  localparam int                ModeShrink = 2;

  typedef struct {
    logic signed [ValW-1:0] rd;
    logic [StW-1:0]         st;
    logic [CountW-1:0]      cnt;
  } reply_t;

  // Shadow copy of the list; computes the reply owed for every accepted request.
  class list_scoreboard;
    logic signed [ValW-1:0] shadow[Depth];
    int unsigned            fill;
    reply_t                 owed[$];
    int unsigned            mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_request(input logic [ReqW-1:0] code, input logic [PosW-1:0] pos,
                               input logic signed [ValW-1:0] val);
      reply_t r;
      int     i;
      r.rd = '0;
      r.st = ST_OK;
      case (code)
        REQ_PUSH: begin
          if (fill >= Depth) r.st = ST_FULL;
          else begin
            shadow[fill] = val;
            fill++;
          end
        end
        REQ_POP, REQ_PEEK: begin
          if (fill == 0) r.st = ST_BAD;
          else begin
            r.rd = shadow[fill-1];
            if (code == REQ_POP) fill--;
          end
        end
        REQ_GET: begin
          if (pos >= fill) r.st = ST_BAD;
          else r.rd = shadow[pos];
        end
        REQ_SET: begin
          if (pos >= fill) r.st = ST_BAD;
          else shadow[pos] = val;
        end
        REQ_INSERT: begin
          // bad position wins over full
          if (pos > fill) r.st = ST_BAD;
          else if (fill >= Depth) r.st = ST_FULL;
          else begin
            for (i = fill; i > pos; i--) shadow[i] = shadow[i-1];
            shadow[pos] = val;
            fill++;
          end
        end
        REQ_REMOVE: begin
          if (pos >= fill) r.st = ST_BAD;
          else begin
            for (i = pos; i + 1 < fill; i++) shadow[i] = shadow[i+1];
            fill--;
          end
        end
        default: r.st = ST_BAD;
      endcase
      r.cnt = fill[CountW-1:0];
      owed.push_back(r);
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(input logic [39:0] d);
      reply_t want;
      if (owed.size() == 0) begin
        flag($sformatf("result with nothing owed: data=%h", d));
        return;
      end
      want = owed.pop_front();
      if (d[31:0] !== want.rd || d[33:32] !== want.st || d[38:34] !== want.cnt ||
          d[39] !== 1'b0)
        flag($sformatf("exp rd=%h st=%0d cnt=%0d pad=0, got rd=%h st=%0d cnt=%0d pad=%b",
                       want.rd, want.st, want.cnt, d[31:0], d[33:32], d[38:34], d[39]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic [39:0] req_data = '0;
  logic        rsp_ready = 1'b0;
  logic        req_ready;
  logic        rsp_valid;
  logic [39:0] rsp_data;

  bit             no_idle = 1'b0;
  int unsigned    idle_cycles = 0;
  list_scoreboard sb = new();

  indexed_list_store_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (rsp_valid),
    .m_axis_tready_i (rsp_ready),
    .m_axis_tdata_o  (rsp_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Presents one request and returns at the edge where it is accepted; valid stays up.
  task automatic send_req(input logic [ReqW-1:0] code, input logic [PosW-1:0] pos,
                          input logic signed [ValW-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= {val, pos, code};
    do @(posedge clk_i); while (!req_ready);
    sb.note_request(code, pos, val);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ReqW-1:0] pick_req(input int mode);
    int grow_pct;
    int r;
    grow_pct = (mode == ModeGrow) ? 75 : (mode == ModeShrink) ? 15 : 40;
    if ($urandom_range(0, 99) < grow_pct) return $urandom_range(0, 1) ? REQ_PUSH : REQ_INSERT;
    r = $urandom_range(0, 99);
    if (r < 30) return REQ_POP;
    if (r < 60) return REQ_REMOVE;
    if (r < 70) return REQ_PEEK;
    if (r < 85) return REQ_GET;
    if (r < 98) return REQ_SET;
    return ReqUnused;
  endfunction

  task automatic random_phase(input int mode, input int n);
    logic [ReqW-1:0] code;
    logic [PosW-1:0] pos;
    int unsigned     c;
    repeat (n) begin
      c    = sb.fill;
      code = pick_req(mode);
      if ($urandom_range(0, 4) == 0) pos = PosW'($urandom_range(0, Depth));
      else if (code == REQ_INSERT) pos = PosW'($urandom_range(0, c));
      else pos = (c == 0) ? '0 : PosW'($urandom_range(0, c - 1));
      send_req(code, pos, pick_value());
    end
  endtask

  // Sink side: random stall before each result, then take it.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid);
      sb.check_result(rsp_data);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int i;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty list: every read or out-of-range index is bad; then a short list is built, read and emptied
    send_req(REQ_PEEK, 0, pick_value());
    send_req(REQ_POP, 0, pick_value());
    send_req(REQ_GET, 0, pick_value());
    send_req(REQ_SET, 0, pick_value());
    send_req(REQ_REMOVE, 0, pick_value());
    send_req(REQ_INSERT, 1, pick_value());
    send_req(ReqUnused, 0, pick_value());
    send_req(REQ_PUSH, 0, 32'h7fff_ffff);
    send_req(REQ_INSERT, 0, 32'h8000_0000);
    send_req(REQ_PUSH, 0, 32'hffff_ffff);
    send_req(REQ_INSERT, 3, 32'h0);           // insert at the end
    send_req(REQ_INSERT, 5, pick_value());    // past the end
    send_req(REQ_GET, 0, pick_value());
    send_req(REQ_GET, 3, pick_value());
    send_req(REQ_GET, 4, pick_value());
    send_req(REQ_GET, 16, pick_value());
    send_req(REQ_SET, 1, 32'h5a5a_a5a5);
    send_req(REQ_PEEK, 31, pick_value());
    send_req(REQ_REMOVE, 1, pick_value());
    send_req(REQ_REMOVE, 3, pick_value());
    send_req(REQ_REMOVE, 2, pick_value());    // last entry
    send_req(REQ_POP, 0, pick_value());
    send_req(REQ_POP, 0, pick_value());
    send_req(REQ_POP, 0, pick_value());
    drain();

    for (i = 0; i < 18; i++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      random_phase(i % 3, 60);
      if (i % 4 == 3) drain();
    end
    no_idle = 1'b0;

    drain();
    repeat (5) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/ils_pkg.sv
hdl/ils_entry_array.sv
hdl/indexed_list_store_core.sv
tb/sv/indexed_list_store_core_tb.sv
